[rtl/core/rrps_pkg.sv]
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared codes and types for the round-robin process scheduler.
// ----------------------------------------------------------------------------
package rrps_pkg;

    // request actions
    localparam logic [1:0] ACT_INIT   = 2'd0;
    localparam logic [1:0] ACT_CREATE = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_YIELD  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    localparam int OUT_PID_W = 8;
    localparam int OUT_CNT_W = 5;

    // per-cycle command shared by every queue cell
    typedef struct packed {
        logic match_en;     // capture target compare
        logic del_shift;    // close the gap left by a removed entry
        logic sched_shift;  // pop the head, every cell moves left
    } rrps_cell_ctrl_t;

endpackage

[rtl/core/rrps_cell.sv]
// ----------------------------------------------------------------------------
// rrps_cell
// One ready-queue slot: holds an ID, compares it with the delete target and
// takes its right neighbour's ID when the queue closes up.
// ----------------------------------------------------------------------------
module rrps_cell
    import rrps_pkg::*;
#(
    parameter int PID_BITS = 8,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrps_cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [OUT_PID_W-1:0]  target,
    input  logic                  load_en,
    input  logic [PID_BITS-1:0]   load_data,
    input  logic [PID_BITS-1:0]   right_id,
    input  logic                  found_in,
    output logic                  found_out,
    output logic [PID_BITS-1:0]   id
);

    localparam int CMP_W = (PID_BITS > OUT_PID_W) ? PID_BITS : OUT_PID_W;

    logic [PID_BITS-1:0] id_reg;
    logic                match_reg;
    logic                occupied;
    logic                hit;

    assign occupied  = CNT_W'(IDX) < count;
    assign hit       = occupied && (CMP_W'(id_reg) == CMP_W'(target));
    assign found_out = found_in | match_reg;
    assign id        = id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.match_en)
        begin
            match_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            id_reg <= load_data;
        end
        else if (ctrl.sched_shift || (ctrl.del_shift && found_out))
        begin
            id_reg <= right_id;
        end
    end

endmodule

[rtl/core/round_robin_process_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// FIFO ready queue of process IDs built from a row of cells, a running slot
// and an ID counter, driven by init, create, delete and yield requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per item: action and target_pid. m_* returns one
//   result per request: status, new_pid, running_pid, running_valid and
//   ready_count of the state after the request.
//   Requests are taken one at a time. Init and create pass through the exec
//   state, yield through the sched state and delete through match, exec and
//   sched (target compare in every cell, then the gap closes along the cell
//   chain, then the head is scheduled). A request is accepted in the same
//   cycle as the previous result is loaded, so requests never overlap.
//   The result sits in an output register; while the receiver stalls, the
//   finished request holds its result and no further request is taken.
//   After reset nothing runs, the queue is empty and the counter is zero, so
//   a create before any init hands out ID 0. The queue cells themselves are
//   not cleared; only entries below the count are ever used.
// ----------------------------------------------------------------------------
module round_robin_process_scheduler
    import rrps_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int PID_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // action[1:0], target_pid[9:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], new_pid[9:2], running_pid[17:10],
                                   // running_valid[18], ready_count[23:19]
);

    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int IDX_W  = $clog2(MAX_PROCS);
    localparam int CMP_W  = (PID_BITS > OUT_PID_W) ? PID_BITS : OUT_PID_W;
    localparam int CNTO_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MATCH = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SCHED = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           act_reg;
    logic [OUT_PID_W-1:0] target_reg;
    logic [1:0]           status_reg;
    logic [PID_BITS-1:0]  given_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PID_BITS-1:0]  running_reg;
    logic                 present_reg;
    logic [PID_BITS-1:0]  next_id_reg;
    logic                 m_tvalid_reg;
    logic [23:0]          m_tdata_reg;

    logic                 accept;
    logic                 out_free;
    logic [CNT_W:0]       live;
    logic                 full;
    logic                 running_hit;
    logic                 load_any;
    logic [IDX_W-1:0]     load_idx;
    logic [CNT_W-1:0]     tail_dec;
    rrps_cell_ctrl_t      ctrl;

    logic [PID_BITS-1:0]  cell_id [MAX_PROCS];
    logic [MAX_PROCS:0]   found_chain;

    logic [CMP_W-1:0]     given_ext;
    logic [CMP_W-1:0]     running_ext;
    logic [CNTO_W-1:0]    count_ext;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign live        = {1'b0, count_reg} + (CNT_W + 1)'(present_reg);
    assign full        = live >= (CNT_W + 1)'(MAX_PROCS);
    assign running_hit = present_reg && (CMP_W'(running_reg) == CMP_W'(target_reg));
    assign tail_dec    = count_reg - CNT_W'(1);

    always_comb
    begin
        ctrl.match_en    = (state_reg == ST_MATCH);
        ctrl.del_shift   = (state_reg == ST_EXEC) && (act_reg == ACT_DELETE);
        ctrl.sched_shift = (state_reg == ST_SCHED) && (count_reg != '0);
        load_any = 1'b0;
        load_idx = count_reg[IDX_W-1:0];
        // running process joins the tail, after the pop when scheduling
        if ((state_reg == ST_EXEC) && (act_reg == ACT_CREATE) && !full && present_reg)
        begin
            load_any = 1'b1;
        end
        else if (ctrl.sched_shift && present_reg)
        begin
            load_any = 1'b1;
            load_idx = tail_dec[IDX_W-1:0];
        end
    end

    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        logic [PID_BITS-1:0] right;
        if (i == MAX_PROCS - 1)
        begin : g_last
            assign right = cell_id[i];
        end
        else
        begin : g_mid
            assign right = cell_id[i+1];
        end

        rrps_cell #(
            .PID_BITS (PID_BITS),
            .CNT_W    (CNT_W),
            .IDX      (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .target    (target_reg),
            .load_en   (load_any && (load_idx == IDX_W'(i))),
            .load_data (running_reg),
            .right_id  (right),
            .found_in  (found_chain[i]),
            .found_out (found_chain[i+1]),
            .id        (cell_id[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (state_reg == ST_DONE && out_free)
                begin
                    state_next = ST_IDLE;
                end
                if (accept)
                begin
                    unique case (s_tdata[1:0])
                        ACT_DELETE: state_next = ST_MATCH;
                        ACT_YIELD:  state_next = ST_SCHED;
                        default:    state_next = ST_EXEC;
                    endcase
                end
            end
            ST_MATCH: state_next = ST_EXEC;
            ST_EXEC:  state_next = (act_reg == ACT_DELETE) ? ST_SCHED : ST_DONE;
            ST_SCHED: state_next = ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign given_ext   = CMP_W'(given_reg);
    assign running_ext = present_reg ? CMP_W'(running_reg) : '0;
    assign count_ext   = CNTO_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            running_reg  <= '0;
            present_reg  <= 1'b0;
            next_id_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (state_reg == ST_EXEC)
            begin
                case (act_reg)
                    ACT_INIT:
                    begin
                        count_reg   <= '0;
                        running_reg <= '0;
                        present_reg <= 1'b1;
                        next_id_reg <= PID_BITS'(1);
                    end
                    ACT_CREATE:
                    begin
                        if (!full)
                        begin
                            next_id_reg <= next_id_reg + PID_BITS'(1);
                            running_reg <= next_id_reg;
                            present_reg <= 1'b1;
                            if (present_reg)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (found_chain[MAX_PROCS])
                        begin
                            count_reg <= tail_dec;
                        end
                        else if (running_hit)
                        begin
                            present_reg <= 1'b0;
                            running_reg <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (ctrl.sched_shift)
            begin
                running_reg <= cell_id[0];
                present_reg <= 1'b1;
                if (!present_reg)
                begin
                    count_reg <= tail_dec;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= s_tdata[1:0];
            target_reg <= s_tdata[9:2];
            status_reg <= STAT_OK;
            given_reg  <= '0;
        end
        else if (state_reg == ST_EXEC)
        begin
            if (act_reg == ACT_CREATE)
            begin
                if (full)
                begin
                    status_reg <= STAT_FULL;
                end
                else
                begin
                    given_reg <= next_id_reg;
                end
            end
            else if (act_reg == ACT_DELETE && !found_chain[MAX_PROCS] && !running_hit)
            begin
                status_reg <= STAT_NOTFOUND;
            end
        end

        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= {count_ext[OUT_CNT_W-1:0], present_reg,
                            running_ext[OUT_PID_W-1:0], given_ext[OUT_PID_W-1:0],
                            status_reg};
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCS))
        else $error("ready queue count beyond capacity");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live <= (CNT_W + 1)'(MAX_PROCS))
        else $error("more live processes than capacity");

    a_sched_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.sched_shift |=> present_reg)
        else $error("scheduling from a non-empty queue left nothing running");

    a_init_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && act_reg == ACT_INIT)
            |=> (count_reg == '0 && present_reg && running_reg == '0))
        else $error("init did not clear the scheduler");
`endif

endmodule

[sim/tb_round_robin_process_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_process_scheduler
// Runs a short table of init, create, delete and yield requests, then about
// 1300 random ones, with random stalls on both streams. Results are checked
// against a model of the ready queue in the bench or a hand-typed table result.
// ----------------------------------------------------------------------------
module tb_round_robin_process_scheduler;
    import rrps_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] new_pid;
        logic [7:0] running_pid;
        logic       running_valid;
        logic [4:0] ready_count;
    } sched_result_t;

    typedef struct packed {
        logic [1:0]    action;
        logic [7:0]    target;
        logic          typed;
        sched_result_t res;
    } sched_row_t;

    localparam sched_result_t NO_RES = '0;

    // hand-typed results only where they follow directly from reset, init or a full table
    localparam sched_row_t DIRECTED_ROWS [0:24] = '{
        '{ACT_YIELD,  8'd0,   1'b1, '{STAT_OK,       8'd0, 8'd0,  1'b0, 5'd0}},
        '{ACT_DELETE, 8'd0,   1'b1, '{STAT_NOTFOUND, 8'd0, 8'd0,  1'b0, 5'd0}},
        '{ACT_CREATE, 8'd0,   1'b1, '{STAT_OK,       8'd0, 8'd0,  1'b1, 5'd0}},
        '{ACT_CREATE, 8'd0,   1'b1, '{STAT_OK,       8'd1, 8'd1,  1'b1, 5'd1}},
        '{ACT_INIT,   8'd255, 1'b1, '{STAT_OK,       8'd0, 8'd0,  1'b1, 5'd0}},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b0, NO_RES},
        '{ACT_CREATE, 8'd0,   1'b1, '{STAT_FULL,     8'd0, 8'd15, 1'b1, 5'd15}},
        '{ACT_DELETE, 8'd255, 1'b0, NO_RES},
        '{ACT_DELETE, 8'd0,   1'b0, NO_RES},
        '{ACT_YIELD,  8'd0,   1'b0, NO_RES},
        '{ACT_DELETE, 8'd2,   1'b0, NO_RES}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // action[1:0], target_pid[9:2], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status[1:0], new_pid[9:2], running_pid[17:10],
                            // running_valid[18], ready_count[23:19]

    // scheduler state as the bench sees it
    logic [7:0]    ready_ids [$];
    logic [7:0]    running_id;
    logic          running_present;
    logic [7:0]    next_id;
    sched_result_t awaited_results [$];
    int            errors;

    round_robin_process_scheduler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // head runs, the old running process (if any) goes to the tail
    task automatic rotate_ready_queue();
        logic [7:0] head;
        if (ready_ids.size() == 0)
            return;
        head = ready_ids.pop_front();
        if (running_present)
            ready_ids.push_back(running_id);
        running_id      = head;
        running_present = 1'b1;
    endtask

    task automatic apply_request(input logic [1:0] action, input logic [7:0] target,
                                 output sched_result_t res);
        int  idx;
        logic [7:0] given;
        idx   = -1;
        given = '0;
        res   = '0;
        res.status = STAT_OK;
        case (action)
            ACT_INIT:
            begin
                ready_ids.delete();
                running_id      = '0;
                running_present = 1'b1;
                next_id         = 8'd1;
            end
            ACT_CREATE:
            begin
                if (ready_ids.size() + int'(running_present) >= QUEUE_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    given   = next_id;
                    next_id = next_id + 8'd1;
                    if (running_present)
                        ready_ids.push_back(running_id);
                    running_id      = given;
                    running_present = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                // first queued match wins over the running slot
                foreach (ready_ids[i])
                    if (idx < 0 && ready_ids[i] == target)
                        idx = i;
                if (idx >= 0)
                    ready_ids.delete(idx);
                else if (running_present && running_id == target)
                begin
                    running_present = 1'b0;
                    running_id      = '0;
                end
                else
                    res.status = STAT_NOTFOUND;
                rotate_ready_queue();
            end
            default:
                rotate_ready_queue();
        endcase
        res.new_pid       = given;
        res.running_pid   = running_present ? running_id : 8'd0;
        res.running_valid = running_present;
        res.ready_count   = 5'(ready_ids.size());
    endtask

    function automatic logic [7:0] pick_live_pid();
        int n;
        int k;
        n = ready_ids.size() + int'(running_present);
        if (n == 0)
            return 8'($urandom_range(0, 255));
        k = $urandom_range(0, n - 1);
        if (k < ready_ids.size())
            return ready_ids[k];
        return running_id;
    endfunction

    task automatic send_request(input logic [1:0] action, input logic [7:0] target,
                                input logic typed, input sched_result_t typed_res);
        sched_result_t res;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, target, action};
        do
            @(posedge clk);
        while (!s_tready);
        apply_request(action, target, res);
        awaited_results.push_back(typed ? typed_res : res);
    endtask

    // sender: holds valid low for a random number of cycles, or not at all
    task automatic sender_gap(input bit busy);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!busy)
        begin
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [1:0] action;
        logic [7:0] target;
        int r;
        int drain;
        bit busy;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        errors   = 0;
        ready_ids.delete();
        running_id      = '0;
        running_present = 1'b0;
        next_id         = '0;
        busy            = 1'b0;
        @(posedge rst_n);

        foreach (DIRECTED_ROWS[i])
        begin
            send_request(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].target,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
            sender_gap(busy);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // stretches with and without sender gaps, chosen at random
            if (n % 40 == 0)
                busy = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            target = 8'($urandom_range(0, 255));
            if (r < 2)
                action = ACT_INIT;
            else if (r < 40)
                action = ACT_CREATE;
            else if (r < 68)
            begin
                action = ACT_DELETE;
                if ($urandom_range(0, 3) != 0)
                    target = pick_live_pid();
            end
            else if (r < 93)
                action = ACT_YIELD;
            else
                action = 2'($urandom_range(0, 3));
            send_request(action, target, 1'b0, NO_RES);
            sender_gap(busy);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        drain = 0;
        while (awaited_results.size() > 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (awaited_results.size() > 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver back-pressure, with one long hold-off so the block stalls its input
    initial
    begin
        int cyc;
        int stall_left;
        bit steady;
        m_tready   = 1'b0;
        cyc        = 0;
        stall_left = 0;
        steady     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 60 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (cyc >= 800 && cyc < 1100)
                m_tready <= 1'b0;
            else if (steady)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                          : $urandom_range(1, 3);
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        sched_result_t got;
        sched_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.status        = m_tdata[1:0];
                got.new_pid       = m_tdata[9:2];
                got.running_pid   = m_tdata[17:10];
                got.running_valid = m_tdata[18];
                got.ready_count   = m_tdata[23:19];
                if (awaited_results.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.new_pid !== want.new_pid)
                    begin
                        $error("new_pid: expected %0d, got %0d", want.new_pid, got.new_pid);
                        errors++;
                    end
                    if (got.running_pid !== want.running_pid)
                    begin
                        $error("running_pid: expected %0d, got %0d",
                               want.running_pid, got.running_pid);
                        errors++;
                    end
                    if (got.running_valid !== want.running_valid)
                    begin
                        $error("running_valid: expected %0d, got %0d",
                               want.running_valid, got.running_valid);
                        errors++;
                    end
                    if (got.ready_count !== want.ready_count)
                    begin
                        $error("ready_count: expected %0d, got %0d",
                               want.ready_count, got.ready_count);
                        errors++;
                    end
                end
            end
        end
    end

endmodule
